FILE: rtl/core/teb_pkg.sv
package teb_pkg;

   localparam int NUM_SOURCES = 8;
   localparam int QUEUE_DEPTH = 16;
   localparam int TAG_BITS = 16;

   localparam int MODE_BITS = 2;
   localparam int SOURCE_BITS = 3;
   localparam int TRIGGER_BITS = 32;
   localparam int FRAG_TAG_BITS = 16;
   localparam int KIND_BITS = 2;

   localparam int SRC_W = $clog2(NUM_SOURCES);
   localparam int PTR_W = $clog2(QUEUE_DEPTH);
   localparam int CNT_W = $clog2(QUEUE_DEPTH + 1);
   localparam int TAG_W = (TAG_BITS < FRAG_TAG_BITS) ? TAG_BITS : FRAG_TAG_BITS;
   localparam int STORE_DEPTH = NUM_SOURCES * QUEUE_DEPTH;
   localparam int STORE_ADDR_W = $clog2(STORE_DEPTH);
   localparam int STORE_W = TRIGGER_BITS + TAG_W;

   localparam logic [MODE_BITS-1:0] MODE_RECEIVE = 2'd0;
   localparam logic [MODE_BITS-1:0] MODE_CONNECT = 2'd1;
   localparam logic [MODE_BITS-1:0] MODE_DISCONNECT = 2'd2;

   localparam logic [KIND_BITS-1:0] KIND_BUILT = 2'd0;
   localparam logic [KIND_BITS-1:0] KIND_NO_FLAG = 2'd1;
   localparam logic [KIND_BITS-1:0] KIND_FULL = 2'd2;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_DECODE,
      ST_ERROR,
      ST_SCAN_READ,
      ST_SCAN_CHECK,
      ST_EMIT_READ,
      ST_EMIT_SEND,
      ST_PRUNE
   } state_type;

   typedef struct packed {
      logic accept;
      logic sel_src;
      logic connect;
      logic disconnect;
      logic push;
      logic scan_init;
      logic scan_check;
      logic idx_clear;
      logic idx_next;
      logic load_error;
      logic load_built;
      logic pop;
      logic prune;
   } cmd_type;

   typedef struct packed {
      logic [MODE_BITS-1:0] mode;
      logic trigger_flag;
      logic src_valid;
      logic queue_full;
      logic idx_known;
      logic sel_empty;
      logic idx_last;
      logic idx_in_mask;
      logic mask_done;
      logic rsp_free;
   } status_type;

endpackage

FILE: rtl/core/teb_req_if.sv
interface teb_req_if import teb_pkg::*; ();
   logic valid;
   logic ready;
   logic [MODE_BITS-1:0] mode;
   logic [SOURCE_BITS-1:0] source_id;
   logic [TRIGGER_BITS-1:0] trigger_number;
   logic [FRAG_TAG_BITS-1:0] fragment_tag;
   logic trigger_flag;

   modport source (
      output valid, mode, source_id, trigger_number, fragment_tag, trigger_flag,
      input ready
   );
   modport sink (
      input valid, mode, source_id, trigger_number, fragment_tag, trigger_flag,
      output ready
   );
endinterface

FILE: rtl/core/teb_rsp_if.sv
interface teb_rsp_if import teb_pkg::*; ();
   logic valid;
   logic ready;
   logic [KIND_BITS-1:0] kind;
   logic [TRIGGER_BITS-1:0] built_trigger;
   logic [SOURCE_BITS-1:0] from_source;
   logic [FRAG_TAG_BITS-1:0] sub_tag;
   logic last;

   modport source (
      output valid, kind, built_trigger, from_source, sub_tag, last,
      input ready
   );
   modport sink (
      input valid, kind, built_trigger, from_source, sub_tag, last,
      output ready
   );
endinterface

FILE: rtl/core/teb_ram.sv
module teb_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 16,
   localparam int ADDR_W = $clog2(DEPTH)
) (
   input  logic              clock,
   input  logic              wr_en,
   input  logic [ADDR_W-1:0] wr_addr,
   input  logic [WIDTH-1:0]  wr_data,
   input  logic [ADDR_W-1:0] rd_addr,
   output logic [WIDTH-1:0]  rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      rd_data_ff <= mem_ff[rd_addr];
   end

   assign rd_data = rd_data_ff;

endmodule

FILE: rtl/core/teb_datapath.sv
module teb_datapath import teb_pkg::*; (
   input  logic                     clock,
   input  logic                     reset,
   input  cmd_type                  cmd,
   output status_type               status,
   input  logic [MODE_BITS-1:0]     req_mode,
   input  logic [SOURCE_BITS-1:0]   req_source,
   input  logic [TRIGGER_BITS-1:0]  req_trigger_number,
   input  logic [FRAG_TAG_BITS-1:0] req_fragment_tag,
   input  logic                     req_trigger_flag,
   input  logic                     rsp_ready,
   output logic                     rsp_valid,
   output logic [KIND_BITS-1:0]     rsp_kind,
   output logic [TRIGGER_BITS-1:0]  rsp_built_trigger,
   output logic [SOURCE_BITS-1:0]   rsp_from_source,
   output logic [FRAG_TAG_BITS-1:0] rsp_sub_tag,
   output logic                     rsp_last
);

   logic [MODE_BITS-1:0] mode_ff;
   logic [SOURCE_BITS-1:0] src_ff;
   logic [TRIGGER_BITS-1:0] trig_ff;
   logic [TAG_W-1:0] tag_ff;
   logic flag_ff;

   logic [NUM_SOURCES-1:0] known_ff, known_in;
   logic [NUM_SOURCES-1:0] inactive_ff, inactive_in;
   logic [PTR_W-1:0] head_ff [NUM_SOURCES];
   logic [PTR_W-1:0] head_in [NUM_SOURCES];
   logic [CNT_W-1:0] count_ff [NUM_SOURCES];
   logic [CNT_W-1:0] count_in [NUM_SOURCES];

   logic [SRC_W-1:0] idx_ff, idx_in;
   logic [TRIGGER_BITS-1:0] min_ff, min_in;
   logic [NUM_SOURCES-1:0] mask_ff, mask_in;

   logic rsp_valid_ff;
   logic [KIND_BITS-1:0] kind_ff;
   logic [TRIGGER_BITS-1:0] built_ff;
   logic [SOURCE_BITS-1:0] from_ff;
   logic [FRAG_TAG_BITS-1:0] sub_tag_ff;
   logic last_ff;

   logic [SRC_W-1:0] src_idx;
   logic [SRC_W-1:0] sel;
   logic [NUM_SOURCES-1:0] sel_bit;
   logic [NUM_SOURCES-1:0] idx_bit;
   logic [PTR_W-1:0] sel_head;
   logic [CNT_W-1:0] sel_count;
   logic [CNT_W:0] tail_sum;
   logic [PTR_W-1:0] tail_ptr;
   logic [PTR_W:0] head_inc;
   logic [PTR_W-1:0] head_next;
   logic [STORE_ADDR_W-1:0] wr_addr;
   logic [STORE_ADDR_W-1:0] rd_addr;
   logic [STORE_W-1:0] rd_data;
   logic [TRIGGER_BITS-1:0] rd_trig;
   logic [TAG_W-1:0] rd_tag;
   logic rsp_free;
   logic mask_done;

   assign src_idx = SRC_W'(src_ff);
   assign sel = cmd.sel_src ? src_idx : idx_ff;
   assign sel_bit = NUM_SOURCES'(1) << sel;
   assign idx_bit = NUM_SOURCES'(1) << idx_ff;
   assign sel_head = head_ff[sel];
   assign sel_count = count_ff[sel];

   assign tail_sum = (CNT_W + 1)'(sel_head) + (CNT_W + 1)'(sel_count);
   assign tail_ptr = (tail_sum >= (CNT_W + 1)'(QUEUE_DEPTH))
                     ? PTR_W'(tail_sum - (CNT_W + 1)'(QUEUE_DEPTH))
                     : PTR_W'(tail_sum);
   assign head_inc = (PTR_W + 1)'(sel_head) + (PTR_W + 1)'(1);
   assign head_next = (head_inc == (PTR_W + 1)'(QUEUE_DEPTH)) ? '0 : PTR_W'(head_inc);

   assign wr_addr = STORE_ADDR_W'(int'(sel) * QUEUE_DEPTH + int'(tail_ptr));
   assign rd_addr = STORE_ADDR_W'(int'(sel) * QUEUE_DEPTH + int'(sel_head));

   teb_ram #(
      .WIDTH(STORE_W),
      .DEPTH(STORE_DEPTH)
   ) u_store (
      .clock  (clock),
      .wr_en  (cmd.push),
      .wr_addr(wr_addr),
      .wr_data({trig_ff, tag_ff}),
      .rd_addr(rd_addr),
      .rd_data(rd_data)
   );

   assign rd_trig = rd_data[STORE_W-1:TAG_W];
   assign rd_tag = rd_data[TAG_W-1:0];
   assign rsp_free = !rsp_valid_ff || rsp_ready;
   assign mask_done = ((mask_ff >> idx_ff) >> 1) == '0;

   always_comb begin
      status.mode = mode_ff;
      status.trigger_flag = flag_ff;
      status.src_valid = int'(src_ff) < NUM_SOURCES;
      status.queue_full = sel_count >= CNT_W'(QUEUE_DEPTH);
      status.idx_known = known_ff[idx_ff];
      status.sel_empty = sel_count == '0;
      status.idx_last = idx_ff == SRC_W'(NUM_SOURCES - 1);
      status.idx_in_mask = mask_ff[idx_ff];
      status.mask_done = mask_done;
      status.rsp_free = rsp_free;
   end

   always_comb begin
      known_in = known_ff;
      inactive_in = inactive_ff;
      head_in = head_ff;
      count_in = count_ff;
      if (cmd.connect) begin
         head_in[sel] = '0;
         count_in[sel] = '0;
         known_in = known_ff | sel_bit;
         inactive_in = inactive_ff & ~sel_bit;
      end
      if (cmd.disconnect) begin
         inactive_in = inactive_ff | sel_bit;
         if ((known_ff & ~inactive_in) == '0) begin
            known_in = '0;
            inactive_in = '0;
            for (int i = 0; i < NUM_SOURCES; i++) begin
               head_in[i] = '0;
               count_in[i] = '0;
            end
         end
      end
      if (cmd.push) begin
         count_in[sel] = sel_count + CNT_W'(1);
         known_in = known_ff | sel_bit;
      end
      if (cmd.pop) begin
         head_in[sel] = head_next;
         count_in[sel] = sel_count - CNT_W'(1);
      end
      if (cmd.prune) begin
         for (int i = 0; i < NUM_SOURCES; i++) begin
            if (count_ff[i] == '0 && known_ff[i] && inactive_ff[i]) begin
               known_in[i] = 1'b0;
               inactive_in[i] = 1'b0;
            end
         end
      end
   end

   always_comb begin
      idx_in = idx_ff;
      if (cmd.idx_clear) begin
         idx_in = '0;
      end else if (cmd.idx_next) begin
         idx_in = idx_ff + SRC_W'(1);
      end
      min_in = min_ff;
      mask_in = mask_ff;
      if (cmd.scan_init) begin
         min_in = '1;
         mask_in = '0;
      end else if (cmd.scan_check) begin
         if (rd_trig < min_ff) begin
            min_in = rd_trig;
            mask_in = idx_bit;
         end else if (rd_trig == min_ff) begin
            mask_in = mask_ff | idx_bit;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         known_ff <= '0;
         inactive_ff <= '0;
         for (int i = 0; i < NUM_SOURCES; i++) begin
            head_ff[i] <= '0;
            count_ff[i] <= '0;
         end
         rsp_valid_ff <= 1'b0;
      end else begin
         known_ff <= known_in;
         inactive_ff <= inactive_in;
         head_ff <= head_in;
         count_ff <= count_in;
         if (cmd.load_error || cmd.load_built) begin
            rsp_valid_ff <= 1'b1;
         end else if (rsp_ready) begin
            rsp_valid_ff <= 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      idx_ff <= idx_in;
      min_ff <= min_in;
      mask_ff <= mask_in;
      if (cmd.accept) begin
         mode_ff <= req_mode;
         src_ff <= req_source;
         trig_ff <= req_trigger_number;
         tag_ff <= TAG_W'(req_fragment_tag);
         flag_ff <= req_trigger_flag;
      end
      if (cmd.load_error) begin
         kind_ff <= flag_ff ? KIND_FULL : KIND_NO_FLAG;
         built_ff <= '0;
         from_ff <= src_ff;
         sub_tag_ff <= '0;
         last_ff <= 1'b1;
      end else if (cmd.load_built) begin
         kind_ff <= KIND_BUILT;
         built_ff <= min_ff;
         from_ff <= SOURCE_BITS'(idx_ff);
         sub_tag_ff <= FRAG_TAG_BITS'(rd_tag);
         last_ff <= mask_done;
      end
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_kind = kind_ff;
   assign rsp_built_trigger = built_ff;
   assign rsp_from_source = from_ff;
   assign rsp_sub_tag = sub_tag_ff;
   assign rsp_last = last_ff;

endmodule

FILE: rtl/core/teb_control.sv
module teb_control import teb_pkg::*; (
   input  logic       clock,
   input  logic       reset,
   input  logic       req_valid,
   output logic       req_ready,
   input  status_type status,
   output cmd_type    cmd
);

   state_type state_ff, state_in;

   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         ST_IDLE: begin
            if (req_valid) begin
               state_in = ST_DECODE;
            end
         end
         ST_DECODE: begin
            state_in = ST_IDLE;
            if (status.src_valid && status.mode == MODE_RECEIVE) begin
               if (!status.trigger_flag || status.queue_full) begin
                  state_in = ST_ERROR;
               end else begin
                  state_in = ST_SCAN_READ;
               end
            end
         end
         ST_ERROR: begin
            if (status.rsp_free) begin
               state_in = ST_IDLE;
            end
         end
         ST_SCAN_READ: begin
            if (!status.idx_known) begin
               if (status.idx_last) begin
                  state_in = ST_EMIT_READ;
               end
            end else if (status.sel_empty) begin
               state_in = ST_IDLE;
            end else begin
               state_in = ST_SCAN_CHECK;
            end
         end
         ST_SCAN_CHECK: begin
            state_in = status.idx_last ? ST_EMIT_READ : ST_SCAN_READ;
         end
         ST_EMIT_READ: begin
            if (status.idx_in_mask) begin
               state_in = ST_EMIT_SEND;
            end else if (status.idx_last) begin
               state_in = ST_PRUNE;
            end
         end
         ST_EMIT_SEND: begin
            if (status.rsp_free) begin
               state_in = status.mask_done ? ST_PRUNE : ST_EMIT_READ;
            end
         end
         ST_PRUNE: begin
            state_in = ST_IDLE;
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_comb begin
      cmd = '0;
      req_ready = 1'b0;
      unique case (state_ff)
         ST_IDLE: begin
            req_ready = 1'b1;
            cmd.accept = req_valid;
         end
         ST_DECODE: begin
            cmd.sel_src = 1'b1;
            if (status.src_valid) begin
               unique case (status.mode)
                  MODE_CONNECT: begin
                     cmd.connect = 1'b1;
                  end
                  MODE_DISCONNECT: begin
                     cmd.disconnect = 1'b1;
                  end
                  MODE_RECEIVE: begin
                     if (status.trigger_flag && !status.queue_full) begin
                        cmd.push = 1'b1;
                        cmd.scan_init = 1'b1;
                        cmd.idx_clear = 1'b1;
                     end
                  end
                  default: begin
                  end
               endcase
            end
         end
         ST_ERROR: begin
            cmd.load_error = status.rsp_free;
         end
         ST_SCAN_READ: begin
            cmd.idx_clear = !status.idx_known && status.idx_last;
            cmd.idx_next = !status.idx_known && !status.idx_last;
         end
         ST_SCAN_CHECK: begin
            cmd.scan_check = 1'b1;
            cmd.idx_clear = status.idx_last;
            cmd.idx_next = !status.idx_last;
         end
         ST_EMIT_READ: begin
            cmd.idx_next = !status.idx_in_mask && !status.idx_last;
         end
         ST_EMIT_SEND: begin
            if (status.rsp_free) begin
               cmd.load_built = 1'b1;
               cmd.pop = 1'b1;
               cmd.idx_next = !status.mask_done;
            end
         end
         ST_PRUNE: begin
            cmd.prune = 1'b1;
         end
         default: begin
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

endmodule

FILE: rtl/core/trigger_event_builder_core.sv
// Merges fragments from up to NUM_SOURCES sources by trigger number. One item is
// taken at a time; an error result and a received fragment may also wait on the
// result side. For a received fragment, the scan for the smallest head trigger and
// the emission of the matching heads each walk the sources in turn through the
// single read port of the fragment RAM. A received fragment with no flag or into a
// full queue yields one error item; a build yields one item per matching source, in
// ascending source order, the final one marked last. Results sit in an output
// register, so the next item is taken while a result still waits.
module trigger_event_builder_core import teb_pkg::*; (
   input logic          clock,
   input logic          reset,
   teb_req_if.sink      req_port,
   teb_rsp_if.source    rsp_port
);

   cmd_type cmd;
   status_type status;

   teb_control u_control (
      .clock    (clock),
      .reset    (reset),
      .req_valid(req_port.valid),
      .req_ready(req_port.ready),
      .status   (status),
      .cmd      (cmd)
   );

   teb_datapath u_datapath (
      .clock             (clock),
      .reset             (reset),
      .cmd               (cmd),
      .status            (status),
      .req_mode          (req_port.mode),
      .req_source        (req_port.source_id),
      .req_trigger_number(req_port.trigger_number),
      .req_fragment_tag  (req_port.fragment_tag),
      .req_trigger_flag  (req_port.trigger_flag),
      .rsp_ready         (rsp_port.ready),
      .rsp_valid         (rsp_port.valid),
      .rsp_kind          (rsp_port.kind),
      .rsp_built_trigger (rsp_port.built_trigger),
      .rsp_from_source   (rsp_port.from_source),
      .rsp_sub_tag       (rsp_port.sub_tag),
      .rsp_last          (rsp_port.last)
   );

   assert property (@(posedge clock) disable iff (reset)
      req_port.valid && req_port.ready |=> !req_port.ready)
      else $error("An item was accepted while the previous one was in progress.");

   assert property (@(posedge clock) disable iff (reset)
      rsp_port.valid && rsp_port.kind != KIND_BUILT |->
         rsp_port.last && rsp_port.sub_tag == '0 && rsp_port.built_trigger == '0)
      else $error("An error item is not a single zeroed final item.");

   assert property (@(posedge clock) disable iff (reset)
      cmd.push |-> !status.queue_full)
      else $error("A fragment was pushed into a full queue.");

   assert property (@(posedge clock) disable iff (reset)
      cmd.pop |-> !status.sel_empty && status.idx_in_mask)
      else $error("A queue head was popped that was empty or not selected.");

endmodule

FILE: sim/tb_top.sv
module tb_top;
   import teb_pkg::*;

   localparam logic [MODE_BITS-1:0] MODE_UNUSED = 2'd3;
   localparam int RANDOM_ITEMS = 350;
   localparam int HOLD_CYCLES = 400;
   localparam int DRAIN_CYCLES = 64;
   localparam int DRAIN_LIMIT = 100000;

   typedef struct packed {
      logic [MODE_BITS-1:0] mode;
      logic [SOURCE_BITS-1:0] source;
      logic [TRIGGER_BITS-1:0] trigger_number;
      logic [FRAG_TAG_BITS-1:0] fragment_tag;
      logic trigger_flag;
   } frag_item_type;

   typedef struct packed {
      logic [KIND_BITS-1:0] kind;
      logic [TRIGGER_BITS-1:0] built_trigger;
      logic [SOURCE_BITS-1:0] from_source;
      logic [FRAG_TAG_BITS-1:0] sub_tag;
      logic last;
   } sub_event_type;

   typedef enum int {RX_ALWAYS, RX_RANDOM, RX_PATTERN} rx_style_type;

   class event_build_checker;
      logic [NUM_SOURCES-1:0] known;
      logic [NUM_SOURCES-1:0] inactive;
      logic [TRIGGER_BITS-1:0] trig_mem [NUM_SOURCES][QUEUE_DEPTH];
      logic [TAG_W-1:0] tag_mem [NUM_SOURCES][QUEUE_DEPTH];
      int head [NUM_SOURCES];
      int count [NUM_SOURCES];
      sub_event_type expected_sub_events [$];
      int mismatch_count;

      function new();
         mismatch_count = 0;
         clear_all();
      endfunction

      function void clear_all();
         known = '0;
         inactive = '0;
         for (int i = 0; i < NUM_SOURCES; i++) begin
            head[i] = 0;
            count[i] = 0;
         end
      endfunction

      function void expect_error(logic [KIND_BITS-1:0] kind, int src);
         sub_event_type ev;
         ev.kind = kind;
         ev.built_trigger = '0;
         ev.from_source = SOURCE_BITS'(src);
         ev.sub_tag = '0;
         ev.last = 1'b1;
         expected_sub_events.insert(expected_sub_events.size(), ev);
      endfunction

      // Predicts the sub-events caused by one accepted item.
      function void note_item(frag_item_type it);
         logic [NUM_SOURCES-1:0] sel;
         logic [NUM_SOURCES-1:0] emit;
         logic [TRIGGER_BITS-1:0] low_trig;
         sub_event_type ev;
         int src;
         int slot;
         src = int'(it.source);
         if (src >= NUM_SOURCES) return;
         sel = '0;
         sel[src] = 1'b1;
         case (it.mode)
            MODE_CONNECT: begin
               head[src] = 0;
               count[src] = 0;
               known |= sel;
               inactive &= ~sel;
            end
            MODE_DISCONNECT: begin
               inactive |= sel;
               if ((known & ~inactive) == '0) clear_all();
            end
            MODE_RECEIVE: begin
               if (!it.trigger_flag) begin
                  expect_error(KIND_NO_FLAG, src);
                  return;
               end
               if (count[src] >= QUEUE_DEPTH) begin
                  expect_error(KIND_FULL, src);
                  return;
               end
               slot = (head[src] + count[src]) % QUEUE_DEPTH;
               trig_mem[src][slot] = it.trigger_number;
               tag_mem[src][slot] = it.fragment_tag[TAG_W-1:0];
               count[src]++;
               known |= sel;
               low_trig = '1;
               for (int i = 0; i < NUM_SOURCES; i++) begin
                  if (known[i]) begin
                     if (count[i] == 0) return;
                     if (trig_mem[i][head[i]] < low_trig) low_trig = trig_mem[i][head[i]];
                  end
               end
               emit = '0;
               for (int i = 0; i < NUM_SOURCES; i++) begin
                  if (known[i] && trig_mem[i][head[i]] == low_trig) emit[i] = 1'b1;
               end
               for (int i = 0; i < NUM_SOURCES; i++) begin
                  if (emit[i]) begin
                     ev.kind = KIND_BUILT;
                     ev.built_trigger = low_trig;
                     ev.from_source = SOURCE_BITS'(i);
                     ev.sub_tag = FRAG_TAG_BITS'(tag_mem[i][head[i]]);
                     ev.last = ((emit >> (i + 1)) == '0);
                     expected_sub_events.insert(expected_sub_events.size(), ev);
                     head[i] = (head[i] + 1) % QUEUE_DEPTH;
                     count[i]--;
                  end
               end
               for (int i = 0; i < NUM_SOURCES; i++) begin
                  if (known[i] && inactive[i] && count[i] == 0) begin
                     known[i] = 1'b0;
                     inactive[i] = 1'b0;
                  end
               end
            end
            default: begin
            end
         endcase
      endfunction

      function void compare_field(string what, logic [31:0] want, logic [31:0] got);
         if (want !== got) begin
            $display("%0t: %s mismatch, expected %0h actual %0h", $time, what, want, got);
            mismatch_count++;
         end
      endfunction

      function void check_sub_event(sub_event_type got);
         sub_event_type want;
         if (expected_sub_events.size() == 0) begin
            $display({"%0t: unexpected item, expected none actual kind %0d trigger %0h",
                      " src %0d tag %0h last %0d"},
                     $time, got.kind, got.built_trigger, got.from_source, got.sub_tag,
                     got.last);
            mismatch_count++;
            return;
         end
         want = expected_sub_events[0];
         expected_sub_events.delete(0);
         compare_field("kind", 32'(want.kind), 32'(got.kind));
         compare_field("built_trigger", want.built_trigger, got.built_trigger);
         compare_field("from_source", 32'(want.from_source), 32'(got.from_source));
         compare_field("sub_tag", 32'(want.sub_tag), 32'(got.sub_tag));
         compare_field("last", 32'(want.last), 32'(got.last));
      endfunction
   endclass

   logic clock = 1'b0;
   logic reset;
   event_build_checker builder_check;
   int items_sent = 0;
   int burst_left = 0;
   bit hold_off_request = 1'b0;

   teb_req_if frag_bus ();
   teb_rsp_if sub_event_bus ();

   trigger_event_builder_core DUT (
      .clock(clock),
      .reset(reset),
      .req_port(frag_bus),
      .rsp_port(sub_event_bus)
   );

   always begin
      #2 clock = 1'b1;
      #2 clock = 1'b0;
   end

   task automatic send_item(input logic [MODE_BITS-1:0] mode, input int src,
                            input logic [TRIGGER_BITS-1:0] trig,
                            input logic [FRAG_TAG_BITS-1:0] tag, input logic flag);
      frag_item_type it;
      int gap;
      it.mode = mode;
      it.source = SOURCE_BITS'(src);
      it.trigger_number = trig;
      it.fragment_tag = tag;
      it.trigger_flag = flag;
      frag_bus.valid <= 1'b1;
      frag_bus.mode <= it.mode;
      frag_bus.source_id <= it.source;
      frag_bus.trigger_number <= it.trigger_number;
      frag_bus.fragment_tag <= it.fragment_tag;
      frag_bus.trigger_flag <= it.trigger_flag;
      @(posedge clock);
      while (frag_bus.ready !== 1'b1) @(posedge clock);
      builder_check.note_item(it);
      if (it.mode != MODE_UNUSED) items_sent++;
      if (burst_left > 0) begin
         burst_left--;
      end else begin
         gap = $urandom_range(0, 6);
         if (gap > 0) begin
            frag_bus.valid <= 1'b0;
            repeat (gap) @(posedge clock);
         end
         burst_left = ($urandom_range(0, 4) == 0) ? $urandom_range(20, 40)
                                                  : $urandom_range(0, 6);
      end
   endtask

   function automatic void shuffle_sources(output int order [NUM_SOURCES]);
      int j;
      int tmp;
      for (int i = 0; i < NUM_SOURCES; i++) order[i] = i;
      for (int i = NUM_SOURCES - 1; i > 0; i--) begin
         j = $urandom_range(0, i);
         tmp = order[i];
         order[i] = order[j];
         order[j] = tmp;
      end
   endfunction

   task automatic send_noise();
      send_item(MODE_BITS'($urandom_range(0, 3)), $urandom_range(0, NUM_SOURCES - 1),
                $urandom, FRAG_TAG_BITS'($urandom), 1'($urandom_range(0, 1)));
   endtask

   // One run of connects, fragments in trigger order from the connected sources, and
   // disconnects. In a flood run one connected source stays silent, so the other overflows.
   task automatic run_session(input bit flood);
      logic [NUM_SOURCES-1:0] members;
      logic [TRIGGER_BITS-1:0] trig;
      int order [NUM_SOURCES];
      int silent;
      int events;
      int roll;
      members = '0;
      silent = -1;
      if (flood) begin
         silent = $urandom_range(0, NUM_SOURCES - 1);
         members[silent] = 1'b1;
         members[(silent + 1 + $urandom_range(0, NUM_SOURCES - 2)) % NUM_SOURCES] = 1'b1;
         events = $urandom_range(QUEUE_DEPTH + 1, QUEUE_DEPTH + 4);
      end else begin
         repeat ($urandom_range(1, ($urandom_range(0, 1) == 0) ? 3 : NUM_SOURCES))
            members[$urandom_range(0, NUM_SOURCES - 1)] = 1'b1;
         events = $urandom_range(3, 12);
      end
      trig = ($urandom_range(0, 3) == 0) ? 32'hFFFF_FFFF - $urandom_range(0, 20) : $urandom;
      shuffle_sources(order);
      for (int k = 0; k < NUM_SOURCES; k++) begin
         if (members[order[k]])
            send_item(MODE_CONNECT, order[k], $urandom, FRAG_TAG_BITS'($urandom),
                      1'($urandom_range(0, 1)));
      end
      repeat (events) begin
         shuffle_sources(order);
         for (int k = 0; k < NUM_SOURCES; k++) begin
            if (members[order[k]] && order[k] != silent) begin
               roll = $urandom_range(0, 99);
               if (flood || roll < 85)
                  send_item(MODE_RECEIVE, order[k], trig, FRAG_TAG_BITS'($urandom), 1'b1);
               else if (roll < 92)
                  send_item(MODE_RECEIVE, order[k], $urandom, FRAG_TAG_BITS'($urandom), 1'b0);
            end
         end
         if ($urandom_range(0, 15) == 0) send_noise();
         trig += $urandom_range(1, 3);
      end
      shuffle_sources(order);
      if ($urandom_range(0, 3) != 0) begin
         for (int k = 0; k < NUM_SOURCES; k++)
            send_item(MODE_DISCONNECT, order[k], $urandom, FRAG_TAG_BITS'($urandom),
                      1'($urandom_range(0, 1)));
      end else begin
         for (int k = 0; k < NUM_SOURCES; k++) begin
            if (members[order[k]])
               send_item(MODE_DISCONNECT, order[k], $urandom, FRAG_TAG_BITS'($urandom),
                         1'($urandom_range(0, 1)));
         end
      end
   endtask

   initial begin
      int start;
      bit mid_hold_done;
      builder_check = new();
      mid_hold_done = 1'b0;
      reset <= 1'b1;
      frag_bus.valid <= 1'b0;
      frag_bus.mode <= MODE_RECEIVE;
      frag_bus.source_id <= '0;
      frag_bus.trigger_number <= '0;
      frag_bus.fragment_tag <= '0;
      frag_bus.trigger_flag <= 1'b0;
      repeat (4) @(posedge clock);
      reset <= 1'b0;

      send_item(MODE_UNUSED, 3, '1, '1, 1'b1);
      send_item(MODE_RECEIVE, 7, '1, '1, 1'b0);
      // A fragment from a source nobody connected makes it known and builds at once.
      send_item(MODE_RECEIVE, 0, '0, '0, 1'b1);
      send_item(MODE_CONNECT, 1, '0, '0, 1'b0);
      send_item(MODE_CONNECT, 2, '1, '1, 1'b1);
      send_item(MODE_RECEIVE, 1, '1, '1, 1'b1);
      send_item(MODE_RECEIVE, 0, 32'd5, 16'hAAAA, 1'b1);
      send_item(MODE_RECEIVE, 2, 32'd5, 16'h5555, 1'b1);
      // A disconnected source with an empty queue holds up builds until it delivers.
      send_item(MODE_DISCONNECT, 2, '0, '0, 1'b0);
      send_item(MODE_RECEIVE, 0, '1, 16'h0001, 1'b1);
      send_item(MODE_RECEIVE, 2, '1, 16'h0002, 1'b1);
      // Marking an unknown source inactive, then hearing from it, keeps it inactive.
      send_item(MODE_DISCONNECT, 6, '0, '0, 1'b0);
      send_item(MODE_RECEIVE, 6, 32'd7, 16'h0003, 1'b1);
      send_item(MODE_RECEIVE, 1, 32'd7, 16'h0004, 1'b1);
      send_item(MODE_RECEIVE, 0, 32'd7, 16'h0005, 1'b1);
      send_item(MODE_CONNECT, 0, '0, '0, 1'b0);
      send_item(MODE_DISCONNECT, 0, '1, '1, 1'b1);
      send_item(MODE_DISCONNECT, 1, '0, '0, 1'b0);

      start = items_sent;
      run_session(1'b1);
      hold_off_request = 1'b1;
      while (items_sent - start < RANDOM_ITEMS) begin
         if (!mid_hold_done && items_sent - start > RANDOM_ITEMS / 2) begin
            hold_off_request = 1'b1;
            mid_hold_done = 1'b1;
         end
         run_session($urandom_range(0, 7) == 0);
      end
      frag_bus.valid <= 1'b0;

      for (int c = 0; c < DRAIN_LIMIT && builder_check.expected_sub_events.size() != 0; c++)
         @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);
      if (builder_check.expected_sub_events.size() != 0) begin
         $display("%0t: %0d expected items never arrived", $time,
                  builder_check.expected_sub_events.size());
         builder_check.mismatch_count++;
      end
      if (builder_check.mismatch_count == 0)
         $display("trigger_event_builder_core regression: pass");
      else
         $display("trigger_event_builder_core regression: fail");
      $finish;
   end

   initial begin
      sub_event_type got;
      rx_style_type style;
      logic [7:0] pattern;
      int hold_left;
      int style_left;
      int phase;
      hold_left = 0;
      style_left = 0;
      phase = 0;
      style = RX_ALWAYS;
      pattern = 8'hFF;
      sub_event_bus.ready <= 1'b0;
      forever begin
         @(posedge clock);
         if (sub_event_bus.valid === 1'b1 && sub_event_bus.ready === 1'b1) begin
            got.kind = sub_event_bus.kind;
            got.built_trigger = sub_event_bus.built_trigger;
            got.from_source = sub_event_bus.from_source;
            got.sub_tag = sub_event_bus.sub_tag;
            got.last = sub_event_bus.last;
            builder_check.check_sub_event(got);
         end
         if (hold_off_request) begin
            hold_off_request = 1'b0;
            hold_left = HOLD_CYCLES;
         end
         if (style_left == 0) begin
            style = rx_style_type'($urandom_range(0, 2));
            style_left = $urandom_range(30, 300);
            pattern = 8'($urandom_range(1, 255));
         end
         style_left--;
         phase = (phase + 1) % 8;
         if (hold_left > 0) begin
            hold_left--;
            sub_event_bus.ready <= 1'b0;
         end else begin
            case (style)
               RX_ALWAYS: sub_event_bus.ready <= 1'b1;
               RX_RANDOM: sub_event_bus.ready <= ($urandom_range(0, 3) != 0);
               default: sub_event_bus.ready <= pattern[phase];
            endcase
         end
      end
   end

   initial begin
      #4_000_000;
      $display("trigger_event_builder_core regression: fail");
      $finish;
   end

endmodule
